// File: design/pfdsr_pkg.sv
// Package for the periodic finite-difference stencil residual unit.
// Holds field widths, register and operation codes and the stencil tables.
// No dependencies.
package pfdsr_pkg;

    // Word field widths
    localparam int OP_W   = 1;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 16;
    localparam int RES_W  = 32;

    // Configuration registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SEL_W      = 4;
    localparam int FLUX_W     = 2;
    localparam int SPEED_W    = 16;
    localparam int INV_W      = 24;
    localparam int CNT_REG_W  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 3'd4;

    localparam logic [SEL_W-1:0]     RST_SCHEME     = 4'd5;
    localparam logic [FLUX_W-1:0]    RST_FLUX       = 2'd0;
    localparam logic [SPEED_W-1:0]   RST_SPEED      = 16'd4096;
    localparam logic [INV_W-1:0]     RST_INV_SPACE  = 24'd256;
    localparam logic [CNT_REG_W-1:0] RST_NODE_COUNT = 11'd1024;

    localparam logic [OP_W-1:0]   OP_LOAD    = 1'b0;
    localparam logic [OP_W-1:0]   OP_COMPUTE = 1'b1;
    localparam logic [FLUX_W-1:0] FLUX_LINEAR  = 2'd0;
    localparam logic [FLUX_W-1:0] FLUX_BURGERS = 2'd1;

    // Datapath widths: multiplier operands, product, accumulator
    localparam int MA_W   = 34;
    localparam int MB_W   = 25;
    localparam int MP_W   = 59;
    localparam int ACC_W  = 57;
    localparam int CF_W   = 23;
    localparam int OFF_W  = 4;

    // Rounding: tap sum 2^45 -> 2^20, scaled 2^28 -> 2^12
    localparam int SUM_SHIFT = 25;
    localparam int RES_SHIFT = 16;
    localparam logic signed [ACC_W-1:0] SUM_HALF = ACC_W'(57'sd1 <<< (SUM_SHIFT - 1));
    localparam logic signed [MP_W-1:0]  RES_HALF = MP_W'(59'sd1 <<< (RES_SHIFT - 1));
    localparam logic [RES_W-1:0] RES_MAX = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

    // Stencil tables
    localparam int NUM_SCHEMES = 10;
    localparam int TAP_SLOTS   = 7;
    localparam int TAP_W       = 3;
    localparam int NTAP_W      = 4;

    localparam logic [NTAP_W-1:0] TAP_COUNT [NUM_SCHEMES] =
        '{4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd7, 4'd7, 4'd7, 4'd7};

    localparam logic signed [OFF_W-1:0] TAP_OFF [NUM_SCHEMES][TAP_SLOTS] = '{
        '{ 4'sd0, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0},
        '{ 4'sd1,  4'sd0, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd0},
        '{ 4'sd0, -4'sd1, -4'sd2,  4'sd0,  4'sd0,  4'sd0,  4'sd0},
        '{ 4'sd0, -4'sd1, -4'sd2, -4'sd3,  4'sd0,  4'sd0,  4'sd0},
        '{ 4'sd1,  4'sd0, -4'sd1, -4'sd2,  4'sd0,  4'sd0,  4'sd0},
        '{ 4'sd2,  4'sd1,  4'sd0, -4'sd1, -4'sd2,  4'sd0,  4'sd0},
        '{ 4'sd3,  4'sd2,  4'sd1,  4'sd0, -4'sd1, -4'sd2, -4'sd3},
        '{ 4'sd2,  4'sd1,  4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4},
        '{ 4'sd3,  4'sd2,  4'sd1,  4'sd0, -4'sd1, -4'sd2, -4'sd3},
        '{ 4'sd3,  4'sd2,  4'sd1,  4'sd0, -4'sd1, -4'sd2, -4'sd3}
    };

    // Weights times 2^20, rounded to nearest
    localparam logic signed [CF_W-1:0] TAP_COEF [NUM_SCHEMES][TAP_SLOTS] = '{
        '{ 23'sd1048576, -23'sd1048576, 23'sd0, 23'sd0, 23'sd0, 23'sd0, 23'sd0},
        '{ 23'sd524288, 23'sd0, -23'sd524288, 23'sd0, 23'sd0, 23'sd0, 23'sd0},
        '{ 23'sd1572864, -23'sd2097152, 23'sd524288, 23'sd0, 23'sd0, 23'sd0, 23'sd0},
        '{ 23'sd1922389, -23'sd3145728, 23'sd1572864, -23'sd349525,
           23'sd0, 23'sd0, 23'sd0},
        '{ 23'sd349525, 23'sd524288, -23'sd1048576, 23'sd174763,
           23'sd0, 23'sd0, 23'sd0},
        '{-23'sd87381, 23'sd699051, 23'sd0, -23'sd699051, 23'sd87381,
           23'sd0, 23'sd0},
        '{ 23'sd17476, -23'sd157286, 23'sd786432, 23'sd0, -23'sd786432,
           23'sd157286, -23'sd17476},
        '{-23'sd34953, 23'sd419430, 23'sd611669, -23'sd1398101, 23'sd524288,
          -23'sd139810, 23'sd17476},
        '{ 23'sd21856, -23'sd174804, 23'sd808329, 23'sd0, -23'sd808329,
           23'sd174804, -23'sd21856},
        '{ 23'sd24962, -23'sd184392, 23'sd818187, 23'sd0, -23'sd818187,
           23'sd184392, -23'sd24962}
    };

    // Unused scheme codes have no taps
    function automatic logic [NTAP_W-1:0] tap_count(input logic [SEL_W-1:0] sel);
        logic [NTAP_W-1:0] n;
        n = '0;
        if (sel < SEL_W'(NUM_SCHEMES)) begin
            n = TAP_COUNT[sel];
        end
        return n;
    endfunction

    function automatic logic signed [OFF_W-1:0] tap_offset(input logic [SEL_W-1:0] sel,
                                                           input logic [TAP_W-1:0] k);
        logic signed [OFF_W-1:0] o;
        o = '0;
        if (sel < SEL_W'(NUM_SCHEMES)) begin
            o = TAP_OFF[sel][k];
        end
        return o;
    endfunction

    function automatic logic signed [CF_W-1:0] tap_coef(input logic [SEL_W-1:0] sel,
                                                        input logic [TAP_W-1:0] k);
        logic signed [CF_W-1:0] c;
        c = '0;
        if (sel < SEL_W'(NUM_SCHEMES)) begin
            c = TAP_COEF[sel][k];
        end
        return c;
    endfunction

endpackage

// File: design/pfdsr_in_if.sv
// Input channel of the stencil residual unit: valid/ready plus the item word.
// Depends on pfdsr_pkg for field widths.
interface pfdsr_in_if import pfdsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [IDX_W-1:0]        node_index;
    logic signed [VAL_W-1:0] node_value;

    modport source (output valid, output operation, output node_index, output node_value,
                    input ready);
    modport sink   (input valid, input operation, input node_index, input node_value,
                    output ready);
endinterface

// File: design/pfdsr_out_if.sv
// Result channel of the stencil residual unit: valid/ready plus the result word.
// Depends on pfdsr_pkg for field widths.
interface pfdsr_out_if import pfdsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        result_index;
    logic signed [RES_W-1:0] residual;

    modport source (output valid, output result_index, output residual, input ready);
    modport sink   (input valid, input result_index, input residual, output ready);
endinterface

// File: design/pfdsr_mul.sv
// Shared signed multiplier with registered product.
// Used for flux, tap weighting and final scaling. Depends on pfdsr_pkg.
module pfdsr_mul import pfdsr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [MA_W-1:0] i_a,
    input  logic signed [MB_W-1:0] i_b,
    output logic signed [MP_W-1:0] o_p
);
    logic signed [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= MP_W'(i_a) * MP_W'(i_b);
        end
    end

    assign o_p = r_p;
endmodule

// File: design/pfdsr_node_mem.sv
// Node value store: one write port, one registered read port.
// Contents undefined until written. Depends on pfdsr_pkg.
module pfdsr_node_mem import pfdsr_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [VAL_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic signed [VAL_W-1:0] o_rdata
);
    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/periodic_fd_stencil_residual_unit.sv
// Periodic finite-difference stencil residual unit (top level).
// Depends on pfdsr_pkg, pfdsr_in_if, pfdsr_out_if, pfdsr_mul, pfdsr_node_mem.
//
// Usage:
//   i_item word: operation 0 loads node_value into node node_index (ignored when the
//   index is past the store). operation 1 computes the residual at node_index, minus
//   the scaled flux derivative, and returns one o_result word; an index at or past the
//   effective node count returns nothing. Config writes (i_cfg_we/index/data) are
//   taken any cycle but must only happen while the unit is idle.
// Sequence:
//   Loads can be accepted back to back while the unit is idle.
//   A compute holds ready low from acceptance until its result is posted
//   (read, flux multiply, tap multiply, accumulate per tap, then round, scale,
//   finish), so no new item is taken until it completes. A scheme with no taps
//   goes straight to round. The single shared multiplier serializes the steps.
// Stall: the result sits in an output register; ready returns while it waits. A
//   second result waits in the finish step until the register is taken.
// Reset: config registers go to defaults, sequencer idles, no result pending. The
//   node store is not cleared: nodes must be loaded before they are read.
module periodic_fd_stencil_residual_unit import pfdsr_pkg::*; #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_TAPS  = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pfdsr_in_if.sink              i_item,
    pfdsr_out_if.source           o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);   // holds the node count itself
    localparam int SW = CW + 2;                  // signed neighbor arithmetic
    localparam logic [NTAP_W-1:0] TAP_CAP =
        (MAX_TAPS < TAP_SLOTS) ? NTAP_W'(MAX_TAPS) : NTAP_W'(TAP_SLOTS);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_FLUX  = 3'd2;
    localparam logic [2:0] ST_TAP   = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_RND   = 3'd5;
    localparam logic [2:0] ST_SCALE = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    // ---------------- configuration registers ----------------
    logic [SEL_W-1:0]          r_scheme;
    logic [FLUX_W-1:0]         r_flux;
    logic signed [SPEED_W-1:0] r_speed;
    logic [INV_W-1:0]          r_inv;
    logic [CNT_REG_W-1:0]      r_node_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme     <= RST_SCHEME;
            r_flux       <= RST_FLUX;
            r_speed      <= RST_SPEED;
            r_inv        <= RST_INV_SPACE;
            r_node_count <= RST_NODE_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCHEME:     r_scheme     <= i_cfg_data[SEL_W-1:0];
                CFG_FLUX:       r_flux       <= i_cfg_data[FLUX_W-1:0];
                CFG_SPEED:      r_speed      <= i_cfg_data[SPEED_W-1:0];
                CFG_INV_SPACE:  r_inv        <= i_cfg_data[INV_W-1:0];
                CFG_NODE_COUNT: r_node_count <= i_cfg_data[CNT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer and datapath registers ----------------
    logic [2:0]              r_state, n_state;
    logic [TAP_W-1:0]        r_tap, n_tap;
    logic [NTAP_W-1:0]       r_ntap, n_ntap;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [MA_W-1:0]  r_sum, n_sum;
    logic                    r_out_valid, n_out_valid;
    logic [IDX_W-1:0]        r_out_index, n_out_index;
    logic [RES_W-1:0]        r_out_res, n_out_res;

    // Shared multiplier and node store hookup
    logic                    mul_en;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  mul_p;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic signed [VAL_W-1:0] mem_rdata;

    pfdsr_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    pfdsr_node_mem #(
        .DEPTH (MAX_NODES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_item.node_value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ---------------- input side ----------------
    logic          in_accept;
    logic [CW-1:0] cnt_eff;
    logic          idx_in_grid;
    logic [NTAP_W-1:0] tap_lim;

    assign i_item.ready = (r_state == ST_IDLE);
    assign in_accept    = i_item.valid && i_item.ready;

    // Effective count: clamp to 3..MAX_NODES
    always_comb begin
        if (r_node_count < CNT_REG_W'(3)) begin
            cnt_eff = CW'(3);
        end else if (32'(r_node_count) > MAX_NODES) begin
            cnt_eff = CW'(MAX_NODES);
        end else begin
            cnt_eff = CW'(r_node_count);
        end
    end

    assign idx_in_grid = 32'(i_item.node_index) < 32'(cnt_eff);
    assign tap_lim     = (tap_count(r_scheme) < TAP_CAP) ? tap_count(r_scheme) : TAP_CAP;

    // Loads go straight to the store
    assign mem_we    = in_accept && (i_item.operation == OP_LOAD) &&
                       (32'(i_item.node_index) < MAX_NODES);
    assign mem_waddr = AW'(i_item.node_index);

    // ---------------- periodic neighbor index ----------------
    // Period is count-1; the last node duplicates node 0. At most two wrap steps
    // cover offsets -4..+3 for any period of 2 or more.
    logic signed [SW-1:0] nb_j, nb_p, nb_t0, nb_t1, nb_t2;
    logic                 nb_wrap_hi;

    always_comb begin
        nb_j       = signed'(SW'(r_idx));
        nb_p       = signed'(SW'(cnt_eff)) - SW'(1);
        nb_t0      = nb_j + SW'(tap_offset(r_scheme, r_tap));
        nb_wrap_hi = nb_t0 > nb_p;
        if (nb_t0 < 0) begin
            nb_t1 = nb_t0 + nb_p;
        end else if (nb_wrap_hi) begin
            nb_t1 = nb_t0 - nb_p;
        end else begin
            nb_t1 = nb_t0;
        end
        if (nb_t1 < 0) begin
            nb_t2 = nb_t1 + nb_p;
        end else if (nb_wrap_hi && (nb_t1 >= nb_p)) begin
            nb_t2 = nb_t1 - nb_p;
        end else begin
            nb_t2 = nb_t1;
        end
    end

    assign mem_re    = (r_state == ST_READ);
    assign mem_raddr = AW'(unsigned'(nb_t2));

    // ---------------- multiplier operand select ----------------
    // Flux at scale 2^25: linear 2*a*q, Burgers q*q, else zero.
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            ST_FLUX: begin
                mul_en = 1'b1;
                if (r_flux == FLUX_LINEAR) begin
                    mul_a = MA_W'(signed'({r_speed, 1'b0}));
                    mul_b = MB_W'(mem_rdata);
                end else if (r_flux == FLUX_BURGERS) begin
                    mul_a = MA_W'(mem_rdata);
                    mul_b = MB_W'(mem_rdata);
                end
            end
            ST_TAP: begin
                mul_en = 1'b1;
                mul_a  = signed'(mul_p[MA_W-1:0]);
                mul_b  = MB_W'(tap_coef(r_scheme, r_tap));
            end
            ST_SCALE: begin
                mul_en = 1'b1;
                mul_a  = r_sum;
                mul_b  = signed'(MB_W'(r_inv));
            end
            default: ;
        endcase
    end

    // ---------------- rounding and saturation ----------------
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [MP_W-1:0]  fin_rnd, fin_shift, fin_neg;
    logic [RES_W-1:0]        fin_res;
    logic                    fin_ovf;

    assign acc_rnd   = r_acc + SUM_HALF;
    assign fin_rnd   = mul_p + RES_HALF;
    assign fin_shift = fin_rnd >>> RES_SHIFT;
    assign fin_neg   = -fin_shift;
    // Overflow when the bits above bit 31 are not all copies of the sign
    assign fin_ovf   = !((&fin_neg[MP_W-1:RES_W-1]) || !(|fin_neg[MP_W-1:RES_W-1]));
    assign fin_res   = fin_ovf ? (fin_neg[MP_W-1] ? RES_MIN : RES_MAX)
                               : fin_neg[RES_W-1:0];

    // ---------------- sequencer ----------------
    logic out_free;
    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state     = r_state;
        n_tap       = r_tap;
        n_ntap      = r_ntap;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_index = r_out_index;
        n_out_res   = r_out_res;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_item.operation == OP_COMPUTE) && idx_in_grid) begin
                    n_idx   = i_item.node_index;
                    n_acc   = '0;
                    n_tap   = '0;
                    n_ntap  = tap_lim;
                    n_state = (tap_lim == '0) ? ST_RND : ST_READ;
                end
            end
            ST_READ:  n_state = ST_FLUX;
            ST_FLUX:  n_state = ST_TAP;
            ST_TAP:   n_state = ST_ACC;
            ST_ACC: begin
                n_acc = r_acc + ACC_W'(mul_p);
                if ((NTAP_W'(r_tap) + NTAP_W'(1)) < r_ntap) begin
                    n_tap   = r_tap + TAP_W'(1);
                    n_state = ST_READ;
                end else begin
                    n_state = ST_RND;
                end
            end
            ST_RND: begin
                n_sum   = MA_W'(acc_rnd >>> SUM_SHIFT);
                n_state = ST_SCALE;
            end
            ST_SCALE: n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_idx;
                    n_out_res   = fin_res;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap       <= '0;
            r_ntap      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tap       <= n_tap;
            r_ntap      <= n_ntap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_acc       <= n_acc;
        r_sum       <= n_sum;
        r_out_index <= n_out_index;
        r_out_res   <= n_out_res;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.result_index = r_out_index;
    assign o_result.residual     = signed'(r_out_res);

    // ---------------- assertions ----------------
`ifndef SYNTHESIS
    // Tap counter never runs past the stencil length while taps are in flight
    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_FLUX || r_state == ST_TAP ||
         r_state == ST_ACC) |-> (NTAP_W'(r_tap) < r_ntap))
        else $error("tap counter past stencil length");

    // A result only appears from the finish step
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FIN)
        else $error("result raised outside finish step");

    // Leaving the finish step always posts a result
    a_fin_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && n_state == ST_IDLE) |=> r_out_valid)
        else $error("finish step left without a result");
`endif

endmodule

// File: verif/pfdsr_residual_checker.sv
// Scoreboard for the periodic stencil residual unit: mirrors the node store and
// the register file, predicts each residual word and compares it with the result.
// Depends on pfdsr_pkg, pfdsr_in_if and pfdsr_out_if.
module pfdsr_residual_checker import pfdsr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pfdsr_in_if                   i_item,
    pfdsr_out_if                  i_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX = 1024;

    typedef struct packed {
        logic [IDX_W-1:0]        node;
        logic signed [RES_W-1:0] value;
    } t_residual;

    // mirrored registers and node store
    logic [SEL_W-1:0]          scheme;
    logic [FLUX_W-1:0]         flux;
    logic signed [SPEED_W-1:0] speed;
    logic [INV_W-1:0]          inv_dx;
    logic [CNT_REG_W-1:0]      count;
    logic signed [VAL_W-1:0]   grid [GRID_MAX];

    t_residual residual_q [$];
    int        errors  = 0;
    int        checked = 0;
    int        waiting = 0;

    assign o_errors  = errors;
    assign o_pending = waiting;
    assign o_checked = checked;

    function automatic int grid_span();
        int c;
        c = int'(count);
        if (c < 3) c = 3;
        if (c > GRID_MAX) c = GRID_MAX;
        return c;
    endfunction

    // Weights are 2^20 times the real ones, first tap at the highest offset,
    // offsets step down by one per tap.
    function automatic void stencil_row(input int s, output int taps, output int lead,
                                        output logic [223:0] w);
        taps = 0;
        lead = 0;
        w    = '0;
        case (s)
            0: begin taps = 2; lead = 0;
                w = {32'sd1048576, -32'sd1048576, 160'd0}; end
            1: begin taps = 3; lead = 1;
                w = {32'sd524288, 32'sd0, -32'sd524288, 128'd0}; end
            2: begin taps = 3; lead = 0;
                w = {32'sd1572864, -32'sd2097152, 32'sd524288, 128'd0}; end
            3: begin taps = 4; lead = 0;
                w = {32'sd1922389, -32'sd3145728, 32'sd1572864, -32'sd349525, 96'd0}; end
            4: begin taps = 4; lead = 1;
                w = {32'sd349525, 32'sd524288, -32'sd1048576, 32'sd174763, 96'd0}; end
            5: begin taps = 5; lead = 2;
                w = {-32'sd87381, 32'sd699051, 32'sd0, -32'sd699051, 32'sd87381, 64'd0}; end
            6: begin taps = 7; lead = 3;
                w = {32'sd17476, -32'sd157286, 32'sd786432, 32'sd0, -32'sd786432,
                     32'sd157286, -32'sd17476}; end
            7: begin taps = 7; lead = 2;
                w = {-32'sd34953, 32'sd419430, 32'sd611669, -32'sd1398101, 32'sd524288,
                     -32'sd139810, 32'sd17476}; end
            8: begin taps = 7; lead = 3;
                w = {32'sd21856, -32'sd174804, 32'sd808329, 32'sd0, -32'sd808329,
                     32'sd174804, -32'sd21856}; end
            9: begin taps = 7; lead = 3;
                w = {32'sd24962, -32'sd184392, 32'sd818187, 32'sd0, -32'sd818187,
                     32'sd184392, -32'sd24962}; end
            default: taps = 0; // unused codes: no taps, residual zero
        endcase
    endfunction

    function automatic logic signed [RES_W-1:0] residual_at(input int j);
        int            span, p, taps, lead, k, t, q;
        logic [223:0]  w;
        longint        acc, f, coarse, scaled, res;
        span = grid_span();
        p    = span - 1;
        acc  = 0;
        stencil_row(int'(scheme), taps, lead, w);
        for (k = 0; k < taps; k++) begin
            t = j + lead - k;
            // the last node repeats node 0, so wrap by count - 1
            if (t < 0) t = (p - ((-t) % p)) % p;
            else if (t >= span) t = t % p;
            q = grid[t];
            case (flux)
                FLUX_LINEAR:  f = 2 * longint'(speed) * q;
                FLUX_BURGERS: f = longint'(q) * q;
                default:      f = 0;
            endcase
            acc += f * longint'($signed(w[(6-k)*32 +: 32]));
        end
        // round half up: sum 2^45 -> 2^20, scaled 2^28 -> 2^12
        coarse = (acc + (64'sd1 <<< 24)) >>> 25;
        scaled = coarse * longint'(inv_dx);
        res    = -((scaled + (64'sd1 <<< 15)) >>> 16);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return RES_W'(res);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_residual want;
        if (!i_rst_n) begin
            scheme  = 4'd5;
            flux    = 2'd0;
            speed   = 16'sd4096;
            inv_dx  = 24'd256;
            count   = 11'd1024;
            residual_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCHEME:     scheme = i_cfg_data[SEL_W-1:0];
                    CFG_FLUX:       flux   = i_cfg_data[FLUX_W-1:0];
                    CFG_SPEED:      speed  = i_cfg_data[SPEED_W-1:0];
                    CFG_INV_SPACE:  inv_dx = i_cfg_data[INV_W-1:0];
                    CFG_NODE_COUNT: count  = i_cfg_data[CNT_REG_W-1:0];
                    default: ;
                endcase
            end
            // results first, so a word never meets an expectation pushed this edge
            if (i_result.valid && i_result.ready) begin
                if (residual_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result word, node %0d residual %0d",
                                 $realtime, i_result.result_index, i_result.residual);
                end else begin
                    want = residual_q.pop_front();
                    checked++;
                    if (i_result.result_index !== want.node ||
                        i_result.residual !== want.value) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch: expected node %0d residual %0d,",
                                      " got node %0d residual %0d"},
                                     $realtime, want.node, want.value,
                                     i_result.result_index, i_result.residual);
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.operation == OP_LOAD) begin
                    grid[i_item.node_index] = i_item.node_value;
                end else if (int'(i_item.node_index) < grid_span()) begin
                    want.node  = i_item.node_index;
                    want.value = residual_at(int'(i_item.node_index));
                    residual_q.push_back(want);
                end
            end
        end
        waiting = residual_q.size();
    end

endmodule

// File: verif/periodic_fd_stencil_residual_unit_test.sv
// Testbench top for the periodic stencil residual unit: clock, reset, stimulus,
// register settings and the final verdict.
// Depends on pfdsr_pkg, both channel interfaces, the unit and pfdsr_residual_checker.
module periodic_fd_stencil_residual_unit_test;
    import pfdsr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Worst item: an idle gap, a busy 7-tap compute and a result stall; about
    // 1300 words in all, so this limit leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // Settle time after a drain; a compute past the grid returns nothing and never starts.
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 26;
    localparam int WORDS_PER_SET = 10;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          errors, pending, checked;
    int          words_sent = 0;
    int          settings   = 0;
    int          eff_nodes  = 1024;   // grid size after clamping, tracks node_count
    int          idle_pct   = 15;     // chance of an idle burst per word, both sides
    bit          calm       = 1'b0;   // no idling at all in the closing phases
    int unsigned cycles     = 0;

    pfdsr_in_if  item_ch ();
    pfdsr_out_if result_ch ();

    always #4 i_clk = ~i_clk;

    periodic_fd_stencil_residual_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pfdsr_residual_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .i_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: ready drops in random bursts, changed at negedge.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                result_ch.ready = 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                result_ch.ready = 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                result_ch.ready = 1'b1;
            end
        end
    end

    // Node values: extremes often, so the Burgers square and a large
    // inverse spacing push the residual into saturation.
    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            2:       v = VAL_W'($signed($urandom_range(0, 511)) - 256);
            default: v = VAL_W'($urandom);
        endcase
        return v;
    endfunction

    // One word on the item channel; fields change at negedge only and the
    // word is taken at the first rising edge with ready high.
    task automatic send_word(input logic [OP_W-1:0] op, input int idx,
                             input logic signed [VAL_W-1:0] val);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 8);
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid      = 1'b1;
        item_ch.operation  = op;
        item_ch.node_index = IDX_W'(idx);
        item_ch.node_value = val;
        forever begin
            @(posedge i_clk);
            if (item_ch.ready) break;
        end
        words_sent++;
    endtask

    // Wait until every residual has come back, then idle for the settle
    // time before the registers move.
    task automatic drain();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_setting(input logic [SEL_W-1:0] sel, input logic [FLUX_W-1:0] fl,
                                 input logic [SPEED_W-1:0] sp, input logic [INV_W-1:0] iv,
                                 input logic [CNT_REG_W-1:0] cn);
        write_reg(CFG_SCHEME,     CFG_DATA_W'(sel));
        write_reg(CFG_FLUX,       CFG_DATA_W'(fl));
        write_reg(CFG_SPEED,      CFG_DATA_W'(sp));
        write_reg(CFG_INV_SPACE,  CFG_DATA_W'(iv));
        write_reg(CFG_NODE_COUNT, CFG_DATA_W'(cn));
        // counts below 3 act as 3, above the store size as the store size
        eff_nodes = int'(cn);
        if (eff_nodes < 3) eff_nodes = 3;
        if (eff_nodes > 1024) eff_nodes = 1024;
        settings++;
    endtask

    // Random traffic: about a third loads anywhere in the store (half of
    // them on the live grid), the rest computes, a tenth of them past a grid smaller than the store.
    task automatic random_word();
        int idx;
        if ($urandom_range(0, 99) < 35) begin
            idx = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, eff_nodes - 1);
            send_word(OP_LOAD, idx, pick_value());
        end else begin
            if (eff_nodes < 1024 && $urandom_range(0, 9) == 0)
                idx = $urandom_range(eff_nodes, 1023);
            else
                idx = $urandom_range(0, eff_nodes - 1);
            send_word(OP_COMPUTE, idx, VAL_W'($urandom));
        end
    endtask

    initial begin : stimulus
        int                        ph, i;
        logic [SEL_W-1:0]          sel;
        logic [FLUX_W-1:0]         fl;
        logic [SPEED_W-1:0]        sp;
        logic [INV_W-1:0]          iv;
        logic [CNT_REG_W-1:0]      cn;

        item_ch.valid      = 1'b0;
        item_ch.operation  = OP_LOAD;
        item_ch.node_index = '0;
        item_ch.node_value = '0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // The store powers up undefined: fill every node once so that no
        // later stencil read, at any node count, touches an unwritten node.
        for (i = 0; i < 1024; i++) send_word(OP_LOAD, i, pick_value());

        // Directed, at the reset register values (central4, linear, speed 1,
        // spacing 1, full grid): extreme values around both periodic ends.
        send_word(OP_LOAD,    0,    16'sh8000);
        send_word(OP_LOAD,    1,    16'sh7FFF);
        send_word(OP_LOAD,    2,    16'sh0000);
        send_word(OP_LOAD,    1021, 16'sh7FFF);
        send_word(OP_LOAD,    1022, 16'sh8000);
        send_word(OP_LOAD,    1023, 16'sh7FFF);
        send_word(OP_COMPUTE, 0,    16'sh0000);
        send_word(OP_COMPUTE, 1,    16'sh7FFF);
        send_word(OP_COMPUTE, 2,    16'sh8000);
        send_word(OP_COMPUTE, 1021, 16'sh0000);
        send_word(OP_COMPUTE, 1022, 16'sh0000);
        send_word(OP_COMPUTE, 1023, 16'sh0000);

        // Node count below the minimum acts as 3; the widest stencil then wraps
        // several times, Burgers with full spacing saturates, and indexes at or
        // past the grid return nothing.
        drain();
        apply_setting(4'd7, FLUX_BURGERS, 16'h7FFF, 24'hFF_FFFF, 11'd2);
        send_word(OP_COMPUTE, 0,    16'sh0000);
        send_word(OP_COMPUTE, 1,    16'sh0000);
        send_word(OP_COMPUTE, 2,    16'sh0000);
        send_word(OP_COMPUTE, 3,    16'sh0000);
        send_word(OP_COMPUTE, 1023, 16'sh0000);

        // Random phases. The first sixteen walk every scheme code, the unused
        // ones too; flux, speed, spacing and count cycle through their
        // extremes; later phases draw scheme and flux freely.
        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 15 : 45);
            calm     = (ph >= PHASES - 3);
            if (ph < 16) begin
                sel = SEL_W'(ph);
                fl  = FLUX_W'((ph + ph / 4) % 4);
            end else begin
                sel = SEL_W'($urandom_range(0, 9));
                fl  = FLUX_W'($urandom_range(0, 3));
            end
            case (ph % 5)
                0:       sp = 16'h8000;
                1:       sp = 16'h7FFF;
                2:       sp = 16'h0000;
                default: sp = SPEED_W'($urandom);
            endcase
            case (ph % 4)
                0:       iv = 24'h00_0000;
                1:       iv = 24'hFF_FFFF;
                2:       iv = INV_W'($urandom_range(1, 4096));
                default: iv = INV_W'($urandom);
            endcase
            case (ph % 7)
                0:       cn = 11'd0;
                1:       cn = 11'd2;
                2:       cn = 11'd3;
                3:       cn = CNT_REG_W'($urandom_range(4, 12));
                4:       cn = CNT_REG_W'($urandom_range(13, 64));
                5:       cn = (ph < 14) ? 11'd2047 : 11'd1024;
                default: cn = CNT_REG_W'($urandom_range(3, 1024));
            endcase
            apply_setting(sel, fl, sp, iv, cn);
            repeat (WORDS_PER_SET) random_word();
        end

        drain();
        $display("Sent %0d item words over %0d register settings; %0d residual words compared.",
                 words_sent, settings, checked);
        $display({"Settings spanned all scheme and flux codes, node counts 0 to 2047,",
                  " speed and spacing extremes."});
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
